/* rtl/core/csh_pkg.sv */
// shared types and constants of the charge stamp histogrammer
package csh_pkg;

	// histogram geometry
	localparam int NUM_BINS   = 256;
	localparam int BIN_W      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int HIST_COUNT = 5;
	localparam int MEM_DEPTH  = HIST_COUNT * NUM_BINS;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);
	localparam int HIST_W     = 3;

	// charge and divider sizes
	localparam int CHARGE_W  = 17;
	localparam int PEAK_W    = 9;
	localparam int PRESC_W   = 16;
	localparam int COUNT_W   = 16;
	localparam int ENTRY_W   = 32;
	localparam int DIV_STEPS = CHARGE_W;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);

	// hit word bit positions
	localparam int PEAK_LSB   = 9;
	localparam int HIGH_RANGE = 23;
	localparam int CHAN_LSB   = 17;
	localparam int CHIP_BIT   = 11;

	// job queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HISTO_ENABLE = 2'd0,
		CFG_STAMP_MODE   = 2'd1,
		CFG_PRESCALE     = 2'd2
	} csh_cfg_idx_t;

	// stamp modes
	localparam logic [1:0] MODE_FADC = 2'd1;
	localparam logic [1:0] MODE_ATWD = 2'd2;

	typedef struct packed {
		logic [31:0] hit_word_first;
		logic [31:0] hit_word_third;
	} csh_in_t;

	typedef struct packed {
		logic               updated;
		logic [HIST_W-1:0]  histo_index;
		logic [7:0]         bin_index;
		logic [COUNT_W-1:0] bin_count;
		logic [ENTRY_W-1:0] entry_count;
	} csh_out_t;

	// classified hit handed from front to back
	typedef struct packed {
		logic                skip;
		logic                force_last;
		logic [HIST_W-1:0]   histo;
		logic [CHARGE_W-1:0] value;
		logic [PRESC_W-1:0]  prescale;
	} csh_job_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_ADDR,
		ST_READ,
		ST_UPDATE,
		ST_DONE
	} csh_state_t;

endpackage

/* rtl/core/csh_ram.sv */
// generic single write port ram with registered read
module csh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/csh_fifo.sv */
// short job queue between the classifying front and the histogram back
module csh_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  csh_pkg::csh_job_t push_data,
	output logic              full,
	input  logic              pop,
	output csh_pkg::csh_job_t pop_data,
	output logic              not_empty
);
	import csh_pkg::*;

	csh_job_t          slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = slots_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/core/csh_front.sv */
// configuration registers and hit classification
module csh_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [csh_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [csh_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  csh_pkg::csh_in_t                    in_item,
	input  logic                                queue_full,
	input  logic                                clearing,
	output logic                                push,
	output csh_pkg::csh_job_t                   push_data
);
	import csh_pkg::*;

	logic               enable_q;
	logic [1:0]         mode_q;
	logic [PRESC_W-1:0] prescale_q;

	logic [PEAK_W-1:0]  peak;
	logic [PEAK_W:0]    peak_scaled;
	logic [1:0]         chan;
	logic               chan_over;
	logic [1:0]         atwd_sel;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			mode_q     <= '0;
			prescale_q <= PRESC_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HISTO_ENABLE: enable_q   <= cfg_wdata[0];
				CFG_STAMP_MODE:   mode_q     <= cfg_wdata[1:0];
				CFG_PRESCALE:     prescale_q <= cfg_wdata[PRESC_W-1:0];
				default: ;
			endcase
		end
	end

	// input handshake
	assign in_stall = queue_full | clearing;
	assign push     = in_valid & ~in_stall;

	// field extraction
	assign peak        = in_item.hit_word_third[PEAK_LSB +: PEAK_W];
	assign peak_scaled = in_item.hit_word_third[HIGH_RANGE] ? {peak, 1'b0} : {1'b0, peak};
	assign chan        = in_item.hit_word_third[CHAN_LSB +: 2];
	assign chan_over   = (chan > 2'd1);
	assign atwd_sel    = {in_item.hit_word_first[CHIP_BIT], chan_over | chan[0]};

	// classify the hit by mode
	always_comb begin
		push_data          = '0;
		push_data.prescale = prescale_q;
		if (!enable_q) begin
			push_data.skip = 1'b1;
		end else begin
			unique case (mode_q)
				MODE_FADC: begin
					push_data.skip  = (prescale_q == '0);
					push_data.histo = '0;
					push_data.value = CHARGE_W'(peak_scaled);
				end
				MODE_ATWD: begin
					push_data.force_last = (prescale_q == '0) | chan_over;
					push_data.histo      = HIST_W'(atwd_sel) + HIST_W'(1);
					push_data.value      = in_item.hit_word_third[CHARGE_W-1:0];
				end
				default: begin
					push_data.skip = 1'b1;
				end
			endcase
		end
	end

endmodule

/* rtl/core/csh_back.sv */
// serial divide, bin read-modify-write, entry counters and result register
module csh_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  csh_pkg::csh_job_t job,
	output logic              job_pop,
	output logic              clearing,
	output logic              out_valid,
	input  logic              out_stall,
	output csh_pkg::csh_out_t out_item
);
	import csh_pkg::*;

	csh_state_t          state_q;
	csh_state_t          state_d;
	csh_job_t            job_q;
	logic [PRESC_W-1:0]  rem_q;
	logic [CHARGE_W-1:0] quo_q;
	logic [STEP_W-1:0]   step_q;
	logic [BIN_W-1:0]    bin_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [ADDR_W-1:0]   clr_addr_q;
	logic [ENTRY_W-1:0]  entries_q [HIST_COUNT];
	csh_out_t            res_q;
	csh_out_t            out_item_q;
	logic                out_valid_q;

	logic [CHARGE_W-1:0] trial;
	logic                trial_ge;
	logic [CHARGE_W-1:0] quo_next;
	logic [BIN_W-1:0]    bin_clamped;
	logic [CHARGE_W-1:0] bin_ext;
	logic [COUNT_W-1:0]  count_new;
	logic [ENTRY_W-1:0]  entry_new;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_wr_addr;
	logic [COUNT_W-1:0] ram_wr_data;
	logic               ram_re;
	logic [COUNT_W-1:0] ram_rd_data;
	logic               out_load;
	logic               last_step;

	// one restoring divide step per cycle
	assign trial       = {rem_q, quo_q[CHARGE_W-1]};
	assign trial_ge    = (trial >= CHARGE_W'(job_q.prescale));
	assign quo_next    = {quo_q[CHARGE_W-2:0], trial_ge};
	assign bin_clamped = (quo_next > CHARGE_W'(NUM_BINS - 1)) ?
	                     BIN_W'(NUM_BINS - 1) : quo_next[BIN_W-1:0];
	assign last_step   = (step_q == STEP_W'(DIV_STEPS - 1));

	assign bin_ext   = CHARGE_W'(bin_q);
	assign count_new = ram_rd_data + COUNT_W'(1);
	assign entry_new = entries_q[job_q.histo] + ENTRY_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == ADDR_W'(MEM_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (job_valid) begin
					if (job.skip) begin
						state_d = ST_DONE;
					end else if (job.force_last) begin
						state_d = ST_ADDR;
					end else begin
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (last_step) begin
					state_d = ST_ADDR;
				end
			end
			ST_ADDR:   state_d = ST_READ;
			ST_READ:   state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_DONE;
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_CLEAR;
		endcase
	end

	// state outputs: queue pop, ram control, result load
	always_comb begin
		job_pop     = 1'b0;
		clearing    = 1'b0;
		ram_we      = 1'b0;
		ram_wr_addr = addr_q;
		ram_wr_data = count_new;
		ram_re      = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				clearing    = 1'b1;
				ram_we      = 1'b1;
				ram_wr_addr = clr_addr_q;
				ram_wr_data = '0;
			end
			ST_IDLE:   job_pop  = job_valid;
			ST_READ:   ram_re   = 1'b1;
			ST_UPDATE: ram_we   = 1'b1;
			ST_DONE:   out_load = ~out_valid_q | ~out_stall;
			default: ;
		endcase
	end

	// control state, entry counters, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < HIST_COUNT; i++) begin
				entries_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (state_q == ST_UPDATE) begin
				entries_q[job_q.histo] <= entry_new;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					job_q  <= job;
					rem_q  <= '0;
					quo_q  <= job.value;
					step_q <= '0;
					bin_q  <= BIN_W'(NUM_BINS - 1);
					res_q  <= '0;
				end
			end
			ST_DIV: begin
				rem_q  <= trial_ge ? PRESC_W'(trial - CHARGE_W'(job_q.prescale)) :
				          trial[PRESC_W-1:0];
				quo_q  <= quo_next;
				step_q <= step_q + 1'b1;
				if (last_step) begin
					bin_q <= bin_clamped;
				end
			end
			ST_ADDR: begin
				addr_q <= ADDR_W'(job_q.histo) * ADDR_W'(NUM_BINS) + ADDR_W'(bin_q);
			end
			ST_UPDATE: begin
				res_q.updated     <= 1'b1;
				res_q.histo_index <= job_q.histo;
				res_q.bin_index   <= bin_ext[7:0];
				res_q.bin_count   <= count_new;
				res_q.entry_count <= entry_new;
			end
			default: ;
		endcase
		if (out_load) begin
			out_item_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// bin storage: fadc histogram first, then the four atwd histograms
	csh_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (MEM_DEPTH)
	) u_bins (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_re),
		.rd_addr (addr_q),
		.rd_data (ram_rd_data)
	);

endmodule

/* rtl/core/charge_stamp_histogrammer.sv */
// top level of the charge stamp histogrammer
// Files the charge stamp of each hit into one FADC histogram or one of four ATWD
// histograms and returns exactly one result per hit, with updated low when the hit
// was not filed. After reset a clearing pass zeroes all 5 * NUM_BINS bins with
// in_stall held high; configuration writes are taken during it. A hit that needs a
// divide is popped, divided bit-serially by the prescale, then addressed, read and
// updated in the bin memory (single write port) before its result load. A hit
// forced to the last bin skips the divide, a skipped hit goes straight to result load.
// A two-entry queue lets the front take hits while the back end works, and the result
// register lets the back end work on the next hit while out_stall holds a result.
module charge_stamp_histogrammer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [csh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [csh_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  csh_pkg::csh_in_t               in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output csh_pkg::csh_out_t              out_item
);
	import csh_pkg::*;

	logic     push;
	csh_job_t push_data;
	logic     queue_full;
	logic     job_pop;
	csh_job_t job;
	logic     job_valid;
	logic     clearing;

	// classifying front
	csh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.queue_full (queue_full),
		.clearing   (clearing),
		.push       (push),
		.push_data  (push_data)
	);

	// job queue
	csh_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (job_pop),
		.pop_data  (job),
		.not_empty (job_valid)
	);

	// histogram back end
	csh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

/* rtl/core/csh_checker.sv */
// port-level checks of the charge stamp histogrammer and their bind
module csh_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input csh_pkg::csh_out_t              out_item
);
	import csh_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	// a hit that was not filed reports all zero
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.updated |->
		out_item.histo_index == '0 && out_item.bin_index == '0 &&
		out_item.bin_count == '0 && out_item.entry_count == '0)
		else $error("skipped hit carries nonzero fields");

	// filed hits name one of the five histograms
	a_histo_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.updated |-> out_item.histo_index <= HIST_W'(HIST_COUNT - 1))
		else $error("histogram index out of range");

	// the clearing pass holds off input right after reset
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> in_stall)
		else $error("input taken during clearing pass");

endmodule

bind charge_stamp_histogrammer csh_checker u_csh_checker (.*);

/* bench/charge_stamp_histogrammer_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench of the charge stamp histogrammer
module tb;
	import csh_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam logic [1:0] MODE_OFF   = 2'd0;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int HOLD_CYCLES    = 400;
	localparam int RANDOM_PHASES  = 12;
	localparam int HITS_PER_PHASE = 150;
	localparam int TIMEOUT_NS     = 2_000_000;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	csh_in_t                in_item   = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	csh_out_t               out_item;

	charge_stamp_histogrammer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow copy of the registers and the histograms
	logic                 cfg_enable   = 1'b0;
	logic [1:0]           cfg_mode     = MODE_OFF;
	logic [PRESC_W-1:0]   cfg_prescale = 16'd1;
	logic [COUNT_W-1:0]   fadc_bins [NUM_BINS]    = '{default: '0};
	logic [COUNT_W-1:0]   atwd_bins [4][NUM_BINS] = '{default: '{default: '0}};
	logic [ENTRY_W-1:0]   fadc_total      = '0;
	logic [ENTRY_W-1:0]   atwd_totals [4] = '{default: '0};

	csh_in_t  hits_waiting [$];
	csh_out_t bin_updates_due [$];

	// idling control shared by stimulus, driver and monitor
	int in_gap_pct    = 0;
	int out_stall_pct = 0;
	bit quiet         = 1'b0;
	int hold_asks     = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int stall_left    = 0;
	int gap_left      = 0;

	// run statistics
	int errors          = 0;
	int hits_accepted   = 0;
	int results_checked = 0;
	int fadc_filed      = 0;
	int atwd_filed      = 0;
	int left_alone      = 0;
	int reg_writes      = 0;

	function automatic int unsigned clamp_bin(int unsigned value);
		int unsigned bin;
		bin = value / cfg_prescale;
		if (bin > NUM_BINS - 1)
			bin = NUM_BINS - 1;
		return bin;
	endfunction

	// files one hit into the shadow histograms and returns the update it causes
	function automatic csh_out_t bin_hit(csh_in_t hit);
		csh_out_t    upd;
		int unsigned value;
		int unsigned bin;
		int unsigned chan;
		int unsigned h;
		upd = '0;
		if (!cfg_enable)
			return upd;
		if (cfg_mode == MODE_FADC && cfg_prescale != 0) begin
			value = hit.hit_word_third[PEAK_LSB +: PEAK_W];
			if (hit.hit_word_third[HIGH_RANGE])
				value = value * 2;
			bin = clamp_bin(value);
			fadc_bins[bin]++;
			fadc_total++;
			upd.updated     = 1'b1;
			upd.histo_index = '0;
			upd.bin_index   = 8'(bin);
			upd.bin_count   = fadc_bins[bin];
			upd.entry_count = fadc_total;
		end else if (cfg_mode == MODE_ATWD) begin
			value = hit.hit_word_third[CHARGE_W-1:0];
			bin = (cfg_prescale == 0) ? NUM_BINS - 1 : clamp_bin(value);
			chan = hit.hit_word_third[CHAN_LSB +: 2];
			// out-of-range channel lands in channel 1, last bin
			if (chan > 1) begin
				chan = 1;
				bin = NUM_BINS - 1;
			end
			h = 2 * hit.hit_word_first[CHIP_BIT] + chan;
			atwd_bins[h][bin]++;
			atwd_totals[h]++;
			upd.updated     = 1'b1;
			upd.histo_index = HIST_W'(h + 1);
			upd.bin_index   = 8'(bin);
			upd.bin_count   = atwd_bins[h][bin];
			upd.entry_count = atwd_totals[h];
		end
		return upd;
	endfunction

	// random hit, mostly with charges that spread over the bins of the current prescale
	function automatic csh_in_t make_hit();
		csh_in_t     hit;
		int unsigned reach;
		int unsigned v;
		hit.hit_word_first = $urandom;
		hit.hit_word_third = $urandom;
		reach = ((cfg_prescale == 0) ? 1 : cfg_prescale) * (NUM_BINS + 2);
		if ($urandom_range(0, 3) != 0) begin
			if (cfg_mode == MODE_FADC) begin
				v = $urandom_range(0, (reach > 511) ? 511 : reach);
				hit.hit_word_third[PEAK_LSB +: PEAK_W] = PEAK_W'(v);
			end else begin
				v = $urandom_range(0, (reach > 131071) ? 131071 : reach);
				hit.hit_word_third[CHARGE_W-1:0] = CHARGE_W'(v);
				if ($urandom_range(0, 3) != 0)
					hit.hit_word_third[CHAN_LSB +: 2] = 2'($urandom_range(0, 1));
			end
		end
		return hit;
	endfunction

	function automatic void check_field(string name, longint unsigned want,
		longint unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	task automatic push_hit(logic [31:0] w1, logic [31:0] w3);
		hits_waiting.push_back(csh_in_t'{w1, w3});
	endtask

	// wait until every hit has been taken and every update has come back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (hits_waiting.size() != 0 || in_valid || bin_updates_due.size() != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		wait_drained();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			CFG_HISTO_ENABLE: cfg_enable   = value[0];
			CFG_STAMP_MODE:   cfg_mode     = value[1:0];
			CFG_PRESCALE:     cfg_prescale = value;
			default: ;
		endcase
		reg_writes++;
	endtask

	// hit driver: predicts on every accepted transaction
	always @(posedge clk or negedge arst_n) begin : drive
		logic    next_valid;
		csh_in_t next_hit;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				bin_updates_due.push_back(bin_hit(in_item));
				hits_accepted++;
			end
			// a stalled transaction holds its payload
			if (!(in_valid && in_stall)) begin
				next_valid = 1'b0;
				next_hit   = in_item;
				if (gap_left > 0) begin
					gap_left--;
				end else if (hits_waiting.size() > 0) begin
					if (!quiet && $urandom_range(0, 99) < in_gap_pct) begin
						gap_left = $urandom_range(0, 2);
					end else begin
						next_hit   = hits_waiting.pop_front();
						next_valid = 1'b1;
					end
				end
				in_valid <= next_valid;
				in_item  <= next_hit;
			end
		end
	end

	// result monitor and output stall
	always @(posedge clk or negedge arst_n) begin : watch
		csh_out_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (bin_updates_due.size() == 0) begin
					$error("result with no hit waiting for it: %p", out_item);
					errors++;
				end else begin
					want = bin_updates_due.pop_front();
					check_field("updated", want.updated, out_item.updated);
					check_field("histo_index", want.histo_index, out_item.histo_index);
					check_field("bin_index", want.bin_index, out_item.bin_index);
					check_field("bin_count", want.bin_count, out_item.bin_count);
					check_field("entry_count", want.entry_count, out_item.entry_count);
					results_checked++;
					if (!want.updated)
						left_alone++;
					else if (want.histo_index == 0)
						fadc_filed++;
					else
						atwd_filed++;
				end
			end
			// long hold-off on request, otherwise short random bursts
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 99) < out_stall_pct) begin
				stall_left = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// stimulus sequence
	initial begin : stimulus
		int         p;
		logic [1:0] mode;
		logic [PRESC_W-1:0] presc;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// disabled after reset
		push_hit(32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// peak mode: zero, clamp, high range doubling
		write_reg(CFG_HISTO_ENABLE, 16'd1);
		write_reg(CFG_STAMP_MODE, MODE_FADC);
		write_reg(CFG_PRESCALE, 16'd1);
		push_hit(32'h0, 32'h0000_0000);
		push_hit(32'h0, 32'h0003_FE00);
		push_hit(32'h0, 32'h0080_C800);
		push_hit(32'h0, 32'h0081_9000);
		push_hit(32'h0, 32'h0001_FE00);
		push_hit(32'h0, 32'h0000_0000);

		// peak mode skips hits with zero prescale
		write_reg(CFG_PRESCALE, 16'd0);
		push_hit(32'h0, 32'h0001_2345);

		// charge mode with zero prescale goes to the last bin
		write_reg(CFG_STAMP_MODE, MODE_ATWD);
		push_hit(32'h0000_0800, 32'h0000_0005);

		// both chips, channels 0 and 1, wide charge, channels above 1
		write_reg(CFG_PRESCALE, 16'd1);
		push_hit(32'h0000_0000, 32'h0000_0000);
		push_hit(32'h0000_0800, 32'h0002_00FF);
		push_hit(32'h0000_0000, 32'h0001_FFFF);
		push_hit(32'h0000_0000, 32'h0004_0003);
		push_hit(32'h0000_0800, 32'h0006_0000);
		push_hit(32'hFFFF_F7FF, 32'hFFF9_0010);

		// largest prescale
		write_reg(CFG_PRESCALE, 16'hFFFF);
		push_hit(32'h0, 32'h0001_FFFF);
		push_hit(32'h0, 32'h0000_FFFE);

		// no mode selected
		write_reg(CFG_STAMP_MODE, MODE_SPARE);
		push_hit(32'h0000_0800, 32'h0000_1000);
		write_reg(CFG_STAMP_MODE, MODE_OFF);
		push_hit(32'h0000_0800, 32'h0000_1000);

		// enable write masked to one bit, then a write beyond the register list
		write_reg(CFG_STAMP_MODE, MODE_ATWD);
		write_reg(CFG_HISTO_ENABLE, 16'hFFFE);
		push_hit(32'h0, 32'h0000_0100);
		write_reg(CFG_SPARE, 16'hFFFF);
		write_reg(CFG_HISTO_ENABLE, 16'd1);
		push_hit(32'h0, 32'h0001_FFFF);

		// random settings, each with its own idling pattern
		for (p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 9))
				0:          mode = MODE_OFF;
				1:          mode = MODE_SPARE;
				2, 3, 4, 5: mode = MODE_FADC;
				default:    mode = MODE_ATWD;
			endcase
			case ($urandom_range(0, 7))
				0:       presc = 16'd0;
				1:       presc = 16'd1;
				2:       presc = 16'hFFFF;
				3:       presc = PRESC_W'($urandom_range(2, 8));
				4:       presc = PRESC_W'($urandom);
				default: presc = PRESC_W'($urandom_range(2, 600));
			endcase
			write_reg(CFG_HISTO_ENABLE, {15'($urandom), 1'($urandom_range(0, 9) != 0)});
			write_reg(CFG_STAMP_MODE, {14'($urandom), mode});
			write_reg(CFG_PRESCALE, presc);
			if (p % 4 == 3)
				write_reg(CFG_SPARE, 16'($urandom));
			case (p % 3)
				0: begin
					in_gap_pct    = 0;
					out_stall_pct = 0;
				end
				1: begin
					in_gap_pct    = 20;
					out_stall_pct = 20;
				end
				default: begin
					in_gap_pct    = 50;
					out_stall_pct = 40;
				end
			endcase
			// back-pressure: receiver holds off while hits keep coming
			if (p == RANDOM_PHASES / 2) begin
				in_gap_pct = 0;
				hold_asks++;
				repeat (40) hits_waiting.push_back(make_hit());
				wait_drained();
			end
			repeat (HITS_PER_PHASE) hits_waiting.push_back(make_hit());
			wait_drained();
		end

		// closing stretch without idling
		quiet = 1'b1;
		write_reg(CFG_HISTO_ENABLE, 16'd1);
		write_reg(CFG_STAMP_MODE, MODE_ATWD);
		write_reg(CFG_PRESCALE, 16'd3);
		repeat (60) hits_waiting.push_back(make_hit());
		wait_drained();

		repeat (40) @(negedge clk);
		$display("%0d hits, %0d results: %0d FADC, %0d ATWD, %0d not filed",
			hits_accepted, results_checked, fadc_filed, atwd_filed, left_alone);
		$display("%0d register writes, prescale 0, 1 and 65535 included, one long output hold-off",
			reg_writes);
		if (errors == 0)
			$display("** charge_stamp_histogrammer: PASSED **");
		else
			$display("** charge_stamp_histogrammer: FAILED **");
		$finish;
	end

	// watchdog
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("** charge_stamp_histogrammer: FAILED **");
		$finish;
	end

endmodule
